### rtl/blg_pkg.sv
// blg_pkg: shared types and constants for the battery level gauge
// word layouts of the input and result channels, status codes, level map constants
// no dependencies
package blg_pkg;

  localparam int unsigned LevelW = 14;
  localparam int unsigned MvW    = 15;

  // bus status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_NOT_READY = 2'd2;

  // threshold register after reset
  localparam logic [LevelW-1:0] THRESHOLD_RESET = 14'd250;

  // full-scale level, 100.00 percent
  localparam logic [LevelW-1:0] LEVEL_FULL = 14'd10000;

  // input word: raw power monitor registers
  typedef struct packed {
    logic [15:0]        bus_word;
    logic signed [15:0] current_word;
    logic [15:0]        power_word;
  } blg_in_t;

  // result word
  typedef struct packed {
    logic signed [MvW-1:0] bus_mv;
    logic [1:0]            bus_status;
    logic signed [15:0]    current_units;
    logic [16:0]           power_mw;
    logic [LevelW-1:0]     level_now;
    logic [LevelW-1:0]     level_shown;
    logic                  level_changed;
  } blg_out_t;

endpackage

### rtl/battery_level_gauge.sv
// battery_level_gauge: power monitor word decode, battery level map and display filter
// depends on blg_pkg for channel word types and constants
//
// Usage:
//   in_valid/in_stall/in_data carry one word of raw bus, current and power registers.
//   out_valid/out_stall/out_data return one result word for every input word,
//   in order. A word moves on a rising edge with valid high and stall low.
//   cfg_wr_en/cfg_wr_data write the change threshold (0.01 percent units); write
//   it only while no word is in flight.
//   Path: an accepted word is held in the input register and moves on to the result
//   register once the result register is free; its result can then be taken from
//   the result register.
//   Throughput: one word per cycle when not stalled; the level map and the display
//   filter sit in the single logic stage between the input and result registers.
//   When the receiver stalls, the result register holds its word and the input
//   register still takes one more word; after that in_stall rises until the
//   result is taken.
//   Reset (rst_n low at a clock edge) empties both registers, sets the threshold
//   to 250 and the displayed level to 0.
module battery_level_gauge (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  blg_pkg::blg_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output blg_pkg::blg_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [13:0]      cfg_wr_data
);
  import blg_pkg::*;

  // level map: six linear segments between 4000 mV and 5250 mV
  function automatic logic [LevelW-1:0] level_of_mv(input logic signed [MvW-1:0] v);
    logic [MvW-1:0]    d;
    logic [8:0]        ofs;
    logic [12:0]       x15;
    logic [LevelW-1:0] lvl;
    d   = '0;
    ofs = '0;
    x15 = '0;
    lvl = '0;
    if (v < 15'sd4000) begin
      lvl = '0;
    end else if (v >= 15'sd5250) begin
      lvl = LEVEL_FULL;
    end else if (v >= 15'sd5000) begin
      d   = v - 15'sd5000;
      ofs = d[8:0];
      lvl = 14'd8000 + {2'b00, ofs, 3'b000};
    end else if (v >= 15'sd4700) begin
      // three segments of slope 20, 2000 apart
      if (v >= 15'sd4900) begin
        d   = v - 15'sd4900;
        lvl = 14'd6000;
      end else if (v >= 15'sd4800) begin
        d   = v - 15'sd4800;
        lvl = 14'd4000;
      end else begin
        d   = v - 15'sd4700;
        lvl = 14'd2000;
      end
      ofs = d[8:0];
      lvl = lvl + ({5'b0, ofs} * 14'd20);
    end else if (v >= 15'sd4500) begin
      // slope 7.5, rounded down
      d   = v - 15'sd4500;
      ofs = d[8:0];
      x15 = {4'b0, ofs} * 13'd15;
      lvl = 14'd500 + {2'b00, x15[12:1]};
    end else begin
      d   = v - 15'sd4000;
      ofs = d[8:0];
      lvl = {5'b0, ofs};
    end
    return lvl;
  endfunction

  logic              s1_valid_r;
  blg_in_t           s1_data_r;
  logic              out_valid_r;
  blg_out_t          out_data_r;
  logic [LevelW-1:0] threshold_r;
  logic [LevelW-1:0] stable_r;

  logic              out_free;
  logic              s1_move;
  logic              in_take;

  logic [1:0]            status;
  logic signed [MvW-1:0] mv;
  logic [LevelW-1:0]     lvl;
  logic [LevelW-1:0]     diff;
  logic                  upd;
  blg_out_t              out_data_nxt;
  logic [LevelW-1:0]     stable_nxt;

  // handshake between the two register stages
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // bus word decode
  always_comb begin
    status = STATUS_OK;
    mv     = '0;
    if (!s1_data_r.bus_word[1]) begin
      status = STATUS_NOT_READY;
    end else if (s1_data_r.bus_word[0]) begin
      status = STATUS_OVERFLOW;
    end else begin
      mv = $signed({s1_data_r.bus_word[15:3], 2'b00});
    end
  end

  // level and display filter
  always_comb begin
    lvl  = (status == STATUS_OK) ? level_of_mv(mv) : '0;
    diff = (lvl >= stable_r) ? (lvl - stable_r) : (stable_r - lvl);
    upd  = (stable_r == '0) || (diff >= threshold_r);
    stable_nxt = upd ? lvl : stable_r;

    out_data_nxt.bus_mv        = mv;
    out_data_nxt.bus_status    = status;
    out_data_nxt.current_units = s1_data_r.current_word;
    out_data_nxt.power_mw      = {s1_data_r.power_word, 1'b0};
    out_data_nxt.level_now     = lvl;
    out_data_nxt.level_shown   = stable_nxt;
    out_data_nxt.level_changed = upd;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      threshold_r <= THRESHOLD_RESET;
      stable_r    <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        stable_r    <= stable_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.bus_status != STATUS_OK) |->
      (out_data_r.bus_mv == '0 && out_data_r.level_now == '0))
    else $error("non-ok status with nonzero voltage or level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.level_now <= LEVEL_FULL))
    else $error("level above full scale");

  a_changed_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.level_changed) |->
      (out_data_r.level_shown == out_data_r.level_now))
    else $error("display update does not take the new level");

  a_shown_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(s1_move) |-> (out_data_r.level_shown == stable_r))
    else $error("shown level differs from stored level");

endmodule

### tb/battery_level_gauge_tb.sv
// battery_level_gauge_tb: self-checking testbench for the battery level gauge
// predicts each result word from the decoded bus reading, level map and display filter
// depends on blg_pkg and battery_level_gauge
module battery_level_gauge_tb;
  import blg_pkg::*;

  localparam int LimitCycles = 400000;
  localparam int MaxPrinted  = 40;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  blg_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  blg_out_t   out_data;
  logic       cfg_wr_en;
  logic [13:0] cfg_wr_data;

  // predictor state: threshold register and displayed level
  int thresh_model;
  int shown_model;

  // readings predicted for accepted words, oldest first
  blg_out_t pending_readings[$];

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int walk_mv;
  int words_sent;
  int results_checked;
  int updates_seen;
  int mismatch_count;

  battery_level_gauge DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock, period 4
  always #2 clk = ~clk;

  // six-segment map from millivolts to 0.01 percent units
  function automatic int level_for_mv(int v);
    if (v < 4000) return 0;
    if (v >= 5250) return 10000;
    if (v >= 5000) return 8000 + (v - 5000) * 8;
    if (v >= 4900) return 6000 + (v - 4900) * 20;
    if (v >= 4800) return 4000 + (v - 4800) * 20;
    if (v >= 4700) return 2000 + (v - 4700) * 20;
    if (v >= 4500) return 500 + ((v - 4500) * 15) / 2;
    return v - 4000;
  endfunction

  // expected result word for one accepted word, advances the display filter
  function automatic blg_out_t predict_reading(blg_in_t w);
    blg_out_t   r;
    int         cnt;
    int         mv;
    int         lvl;
    int         diff;
    logic [1:0] st;
    mv = 0;
    if (!w.bus_word[1]) begin
      st = STATUS_NOT_READY;
    end else if (w.bus_word[0]) begin
      st = STATUS_OVERFLOW;
    end else begin
      st = STATUS_OK;
      cnt = $signed(w.bus_word[15:3]);
      mv = cnt * 4;
    end
    lvl = (st == STATUS_OK) ? level_for_mv(mv) : 0;
    diff = (lvl >= shown_model) ? lvl - shown_model : shown_model - lvl;
    r.level_changed = (shown_model == 0) || (diff >= thresh_model);
    if (r.level_changed) shown_model = lvl;
    r.bus_mv        = mv[MvW-1:0];
    r.bus_status    = st;
    r.current_units = w.current_word;
    r.power_mw      = {w.power_word, 1'b0};
    r.level_now     = lvl[LevelW-1:0];
    r.level_shown   = shown_model[LevelW-1:0];
    return r;
  endfunction

  // ready bus word carrying a voltage, spare bit 2 random
  function automatic logic [15:0] ok_word(int mv);
    logic [12:0] cnt;
    logic        spare;
    cnt = 13'(mv / 4);
    spare = 1'($urandom_range(1));
    return {cnt, spare, 2'b10};
  endfunction

  function automatic blg_in_t make_word(logic [15:0] bus, logic [15:0] cur,
                                        logic [15:0] pwr);
    blg_in_t w;
    w.bus_word     = bus;
    w.current_word = cur;
    w.power_word   = pwr;
    return w;
  endfunction

  // mostly a slow voltage walk through the map, some jumps, wild counts and bad status
  function automatic logic [15:0] random_bus_word();
    int          pick;
    logic [15:0] raw;
    pick = $urandom_range(99);
    raw = 16'($urandom_range(65535));
    if (pick < 55) begin
      walk_mv = walk_mv + 4 * (int'($urandom_range(8)) - 4);
      if (walk_mv < 3760) walk_mv = 3760;
      if (walk_mv > 5400) walk_mv = 5400;
      return ok_word(walk_mv);
    end
    if (pick < 70) begin
      walk_mv = 4 * int'($urandom_range(1350, 940));
      return ok_word(walk_mv);
    end
    if (pick < 78) return {raw[15:2], 2'b10};
    if (pick < 89) return {raw[15:2], 1'b0, raw[0]};
    return {raw[15:2], 2'b11};
  endfunction

  task automatic report_mismatch(string what, int got, int want_v);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want_v);
  endtask

  task automatic check_field(string what, int got, int want_v);
    if (got != want_v) report_mismatch(what, got, want_v);
  endtask

  // offer one word, wait for it to be taken, record its prediction
  task automatic send_word(blg_in_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(predict_reading(w));
    words_sent++;
  endtask

  task automatic send_random_words(int n);
    repeat (n)
      send_word(make_word(random_bus_word(), 16'($urandom_range(65535)),
                          16'($urandom_range(65535))));
  endtask

  // stop offering and wait for every predicted reading to come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(logic [13:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    thresh_model = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // status decode corners, count extremes and every segment edge, reset threshold
  task automatic test_directed();
    int edges[$];
    send_idle_pct = 0;
    stall_pct     = 0;
    edges = '{3996, 4000, 4496, 4500, 4504, 4696, 4700, 4796, 4800, 4896, 4900,
              4996, 5000, 5248, 5252};
    send_word(make_word(16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(16'hFFFF, 16'h8000, 16'hFFFF));
    send_word(make_word(16'h0001, 16'h7FFF, 16'h0000));
    send_word(make_word(16'h0003, 16'hFFFF, 16'h0001));
    send_word(make_word(16'hFFFD, 16'h0000, 16'hFFFF));
    send_word(make_word(ok_word(0), 16'h7FFF, 16'hFFFF));
    send_word(make_word(ok_word(16380), 16'h8000, 16'h8000));
    send_word(make_word(ok_word(-16384), 16'h0001, 16'h7FFF));
    send_word(make_word(ok_word(-4), 16'h1234, 16'h0002));
    send_word(make_word(16'hFFFE, 16'hAAAA, 16'h5555));
    foreach (edges[i])
      send_word(make_word(ok_word(edges[i]), 16'($urandom_range(65535)),
                          16'($urandom_range(65535))));
    drain_results();
  endtask

  // zero, one, full scale, above full scale and ordinary thresholds
  task automatic test_threshold_sweep();
    int settings[$];
    settings = '{0, 1, 10000, 16383, int'($urandom_range(9999, 2)), 250};
    send_idle_pct = 29;
    stall_pct     = 29;
    foreach (settings[i]) begin
      write_threshold(14'(settings[i]));
      send_random_words(40);
      drain_results();
    end
  endtask

  // receiver holds off long enough to fill the block while words keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    send_random_words(40);
    drain_results();
  endtask

  // random words under each idling mix, new threshold per phase
  task automatic test_random_phases();
    int send_mix[4];
    int stall_mix[4];
    send_mix  = '{0, 63, 0, 29};
    stall_mix = '{0, 0, 63, 29};
    for (int p = 0; p < 4; p++) begin
      write_threshold(14'($urandom_range(600)));
      send_idle_pct = send_mix[p];
      stall_pct     = stall_mix[p];
      send_random_words(280);
      drain_results();
    end
  endtask

  // receiver: long hold-off when requested, else random stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each taken result word with the oldest prediction
  always @(posedge clk) begin
    blg_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result word with none pending, level_now", out_data.level_now, 0);
      end else begin
        want = pending_readings.pop_front();
        results_checked++;
        if (out_data.level_changed) updates_seen++;
        check_field("bus_mv", out_data.bus_mv, want.bus_mv);
        check_field("bus_status", out_data.bus_status, want.bus_status);
        check_field("current_units", out_data.current_units, want.current_units);
        check_field("power_mw", out_data.power_mw, want.power_mw);
        check_field("level_now", out_data.level_now, want.level_now);
        check_field("level_shown", out_data.level_shown, want.level_shown);
        check_field("level_changed", out_data.level_changed, want.level_changed);
      end
    end
  end

  // main sequence
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    thresh_model    = THRESHOLD_RESET;
    shown_model     = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_left       = 0;
    walk_mv         = 4400;
    words_sent      = 0;
    results_checked = 0;
    updates_seen    = 0;
    mismatch_count  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_threshold_sweep();
    test_backpressure();
    test_random_phases();

    repeat (5) @(posedge clk);
    $display("battery_level_gauge_tb: %0d words sent, %0d results checked, %0d display updates",
             words_sent, results_checked, updates_seen);
    $display("covered status decode, segment edges, threshold extremes, hold-off and idling mixes");
    if (mismatch_count == 0) begin
      $display("battery_level_gauge_tb: PASS");
    end else begin
      $display("battery_level_gauge_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    repeat (LimitCycles) @(posedge clk);
    $display("battery_level_gauge_tb: FAIL");
    $finish;
  end

endmodule

### battery_level_gauge.f
rtl/blg_pkg.sv
rtl/battery_level_gauge.sv
tb/battery_level_gauge_tb.sv
